// ===== hdl/bhsd_pkg.sv =====
package bhsd_pkg;

  localparam int MAX_BUFFER_BYTES = 4096;
  localparam int NUM_BINS         = 256;
  localparam int BIN_W            = $clog2(NUM_BINS);
  localparam int CNT_W            = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int OUT_W            = 13;

  // bin memory write port, with the per-buffer clear of the valid bits
  typedef struct packed {
    logic             en;
    logic             clr;
    logic [BIN_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic             bad;
    logic [OUT_W-1:0] peak;
    logic [OUT_W-1:0] length;
    logic             ovf;
  } verdict_t;

  typedef struct packed {
    logic [CNT_W-1:0] bytes;
    logic [CNT_W-1:0] peak;
  } stat_t;

endpackage

// ===== hdl/byte_histogram_stuck_detector_top.sv =====
// A buffer's verdict is registered at the output as its last byte leaves the update stage.
// Throughput: one byte per cycle; the bin update is a read-modify-write of a one-port-read
// memory, with the previous write forwarded. A stall happens only when a last byte
// reaches the update stage while an earlier verdict still waits at the output.
// Reset: synchronous; clears the counters, the pipeline and the 256 bin valid bits at once,
// so bins read as zero without a clearing pass. The same valid bits clear at each buffer end.
module byte_histogram_stuck_detector_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 sample_byte,
  input  logic                       end_of_buffer,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       buffer_bad,
  output logic [bhsd_pkg::OUT_W-1:0] peak_count,
  output logic [bhsd_pkg::OUT_W-1:0] buffer_length,
  output logic                       length_overflow
);

  logic                       acc;
  logic                       out_free;
  logic [bhsd_pkg::CNT_W-1:0] rd_data;
  logic                       bin_valid;
  logic [bhsd_pkg::BIN_W-1:0] bin_addr;
  bhsd_pkg::wr_t              wr;
  logic                       res_valid;
  bhsd_pkg::verdict_t         res;
  bhsd_pkg::stat_t            stat;

  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  bhsd_bin_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (acc),
    .rd_addr   (sample_byte),
    .rd_data   (rd_data),
    .chk_addr  (bin_addr),
    .chk_valid (bin_valid),
    .wr        (wr)
  );

  bhsd_update u_upd (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .byte_in   (sample_byte),
    .last_in   (end_of_buffer),
    .out_free  (out_free),
    .can_take  (in_ready),
    .rd_data   (rd_data),
    .bin_valid (bin_valid),
    .bin_addr  (bin_addr),
    .wr        (wr),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      buffer_bad      <= res.bad;
      peak_count      <= res.peak;
      buffer_length   <= res.length;
      length_overflow <= res.ovf;
    end
  end

  a_peak_le_len: assert property (@(posedge clk) disable iff (rst)
    stat.peak <= stat.bytes)
    else $error("running peak above byte count");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    stat.bytes <= bhsd_pkg::CNT_W'(bhsd_pkg::MAX_BUFFER_BYTES))
    else $error("byte count beyond buffer limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || out_ready))
    else $error("verdict overwrites a pending result");

  a_write_clears: assert property (@(posedge clk) disable iff (rst)
    wr.clr |=> (stat.bytes == '0 && stat.peak == '0))
    else $error("counters not cleared after buffer end");

endmodule

// ===== hdl/bhsd_bin_mem.sv =====
module bhsd_bin_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [bhsd_pkg::BIN_W-1:0] rd_addr,
  output logic [bhsd_pkg::CNT_W-1:0] rd_data,
  input  logic [bhsd_pkg::BIN_W-1:0] chk_addr,
  output logic                       chk_valid,
  input  bhsd_pkg::wr_t              wr
);

  logic [bhsd_pkg::CNT_W-1:0]    mem [bhsd_pkg::NUM_BINS];
  logic [bhsd_pkg::NUM_BINS-1:0] vbit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // a bin not written since the last buffer end reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
    end else if (wr.clr) begin
      vbit <= '0;
    end else if (wr.en) begin
      vbit[wr.addr] <= 1'b1;
    end
  end

  assign chk_valid = vbit[chk_addr];

endmodule

// ===== hdl/bhsd_update.sv =====
module bhsd_update (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       acc,
  input  logic [bhsd_pkg::BIN_W-1:0] byte_in,
  input  logic                       last_in,
  input  logic                       out_free,
  output logic                       can_take,
  input  logic [bhsd_pkg::CNT_W-1:0] rd_data,
  input  logic                       bin_valid,
  output logic [bhsd_pkg::BIN_W-1:0] bin_addr,
  output bhsd_pkg::wr_t              wr,
  output logic                       res_valid,
  output bhsd_pkg::verdict_t         res,
  output bhsd_pkg::stat_t            stat
);

  logic                       s1_valid;
  logic [bhsd_pkg::BIN_W-1:0] s1_addr;
  logic                       s1_last;
  logic                       fwd_valid;
  logic [bhsd_pkg::BIN_W-1:0] fwd_addr;
  logic [bhsd_pkg::CNT_W-1:0] fwd_val;
  logic [bhsd_pkg::CNT_W-1:0] bytes_seen;
  logic [bhsd_pkg::CNT_W-1:0] running_peak;
  logic                       overflow_seen;

  logic                       s1_fire;
  logic                       full;
  logic [bhsd_pkg::CNT_W-1:0] old_cnt;
  logic [bhsd_pkg::CNT_W-1:0] cnt_inc;
  logic [bhsd_pkg::CNT_W-1:0] bytes_next;
  logic [bhsd_pkg::CNT_W-1:0] peak_next;
  logic                       ovf_next;

  always_comb begin
    s1_fire  = s1_valid && (!s1_last || out_free);
    can_take = !s1_valid || s1_fire;
    full     = bytes_seen >= bhsd_pkg::CNT_W'(bhsd_pkg::MAX_BUFFER_BYTES);
    // the previous write lands in the same cycle as this read: forward it
    if (fwd_valid && fwd_addr == s1_addr) begin
      old_cnt = fwd_val;
    end else if (bin_valid) begin
      old_cnt = rd_data;
    end else begin
      old_cnt = '0;
    end
    cnt_inc    = old_cnt + 1'b1;
    bytes_next = full ? bytes_seen : bytes_seen + 1'b1;
    peak_next  = (!full && cnt_inc > running_peak) ? cnt_inc : running_peak;
    ovf_next   = overflow_seen | full;

    wr.en   = s1_fire && !full;
    wr.clr  = s1_fire && s1_last;
    wr.addr = s1_addr;
    wr.data = cnt_inc;

    res_valid  = s1_fire && s1_last;
    res.bad    = peak_next > (bytes_next >> 1);
    res.peak   = bhsd_pkg::OUT_W'(peak_next);
    res.length = bhsd_pkg::OUT_W'(bytes_next);
    res.ovf    = ovf_next;

    stat.bytes = bytes_seen;
    stat.peak  = running_peak;
  end

  assign bin_addr = s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      fwd_valid     <= 1'b0;
      bytes_seen    <= '0;
      running_peak  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (can_take) begin
        s1_valid <= acc;
      end
      if (acc) begin
        s1_addr <= byte_in;
        s1_last <= last_in;
      end
      if (s1_fire) begin
        if (s1_last) begin
          bytes_seen    <= '0;
          running_peak  <= '0;
          overflow_seen <= 1'b0;
          fwd_valid     <= 1'b0;
        end else begin
          bytes_seen    <= bytes_next;
          running_peak  <= peak_next;
          overflow_seen <= ovf_next;
          if (!full) begin
            fwd_valid <= 1'b1;
            fwd_addr  <= s1_addr;
            fwd_val   <= cnt_inc;
          end
        end
      end
    end
  end

endmodule

// ===== tb/byte_histogram_stuck_detector_top_tb.sv =====
module byte_histogram_stuck_detector_top_tb;

  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_BYTES = 1500;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [7:0]                   sample_byte;
  logic                         end_of_buffer;
  logic                         out_valid;
  logic                         out_ready;
  logic                         buffer_bad;
  logic [bhsd_pkg::OUT_W-1:0]   peak_count;
  logic [bhsd_pkg::OUT_W-1:0]   buffer_length;
  logic                         length_overflow;

  // shadow histogram of the buffer being received
  int unsigned hist_bins [bhsd_pkg::NUM_BINS];
  int unsigned byte_total;
  int unsigned peak_bin;
  logic        saw_overflow;

  bhsd_pkg::verdict_t pending_verdicts[$];
  logic [7:0]         frame_bytes[$];
  int                 error_count;
  int                 bytes_sent;
  int                 idle_cycles;
  bit                 gaps_on;
  bit                 stalls_on;

  byte_histogram_stuck_detector_top DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_byte    (sample_byte),
    .end_of_buffer  (end_of_buffer),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .buffer_bad     (buffer_bad),
    .peak_count     (peak_count),
    .buffer_length  (buffer_length),
    .length_overflow(length_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic clear_histogram();
    foreach (hist_bins[i]) hist_bins[i] = 0;
    byte_total   = 0;
    peak_bin     = 0;
    saw_overflow = 1'b0;
  endtask

  // bytes past the maximum length only raise the overflow flag
  task automatic tally_byte(input logic [7:0] value, input logic is_last);
    bhsd_pkg::verdict_t v;
    if (byte_total >= bhsd_pkg::MAX_BUFFER_BYTES) begin
      saw_overflow = 1'b1;
    end else begin
      hist_bins[value]++;
      byte_total++;
      if (hist_bins[value] > peak_bin) peak_bin = hist_bins[value];
    end
    if (is_last) begin
      v.bad    = (peak_bin > byte_total / 2);
      v.peak   = peak_bin[bhsd_pkg::OUT_W-1:0];
      v.length = byte_total[bhsd_pkg::OUT_W-1:0];
      v.ovf    = saw_overflow;
      pending_verdicts.push_back(v);
      clear_histogram();
    end
  endtask

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    sample_byte   <= value;
    end_of_buffer <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tally_byte(value, is_last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // verdict checker
  always @(posedge clk) begin
    bhsd_pkg::verdict_t v;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected verdict: expected none actual bad=%0d peak=%0d len=%0d ovf=%0d",
                 $time, buffer_bad, peak_count, buffer_length, length_overflow);
        error_count++;
      end else begin
        v = pending_verdicts.pop_front();
        report_field("buffer_bad", 32'(v.bad), 32'(buffer_bad));
        report_field("peak_count", 32'(v.peak), 32'(peak_count));
        report_field("buffer_length", 32'(v.length), 32'(buffer_length));
        report_field("length_overflow", 32'(v.ovf), 32'(length_overflow));
      end
    end
  end

  // receiver stalls: short random drops plus an occasional long hold
  initial begin
    int r;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stalls_on) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
        end else if (r < 93) begin
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(5, 40)) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL byte_histogram_stuck_detector_top");
        $finish;
      end
    end
  end

  task automatic test_small_buffers();
    frame_bytes = '{8'h00};                      send_frame();
    frame_bytes = '{8'hFF};                      send_frame();
    frame_bytes = '{8'hAA, 8'hAA};               send_frame();
    frame_bytes = '{8'h55, 8'hAA};               send_frame();
    // peak equal to half the length is still good
    frame_bytes = '{8'h07, 8'h07, 8'h01, 8'h02}; send_frame();
    frame_bytes = '{8'h07, 8'h07, 8'h07, 8'h01}; send_frame();
    frame_bytes = '{8'h03, 8'h03, 8'h01, 8'h02, 8'h04}; send_frame();
    frame_bytes = '{8'h03, 8'h03, 8'h03, 8'h01, 8'h02}; send_frame();
  endtask

  task automatic test_drain_pause();
    frame_bytes = '{8'h01, 8'h02, 8'h01};
    send_frame();
    frame_bytes = '{8'hF0};
    send_frame();
    wait_drained();
    frame_bytes = '{8'h80, 8'h80};
    send_frame();
  endtask

  task automatic test_random_buffers();
    int start_count;
    int len;
    int kind;
    int pct;
    logic [7:0] dominant;
    logic [7:0] alphabet [4];
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) == 0) wait_drained();
      len = $urandom_range(0, 99);
      if (len < 85)      len = $urandom_range(1, 24);
      else if (len < 98) len = $urandom_range(25, 200);
      else               len = $urandom_range(201, 600);
      kind     = $urandom_range(0, 2);
      pct      = $urandom_range(35, 100);
      dominant = 8'($urandom);
      foreach (alphabet[i]) alphabet[i] = 8'($urandom);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: frame_bytes.push_back(8'($urandom));
          1: frame_bytes.push_back(($urandom_range(1, 100) <= pct) ? dominant : 8'($urandom));
          default: frame_bytes.push_back(alphabet[2'($urandom_range(0, 3))]);
        endcase
      end
      send_frame();
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    sample_byte   = 8'h00;
    end_of_buffer = 1'b0;
    error_count   = 0;
    bytes_sent    = 0;
    idle_cycles   = 0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    clear_histogram();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_small_buffers();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_drain_pause();
    test_random_buffers();

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t mismatch pending verdicts: expected 0 actual %0d",
               $time, pending_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS byte_histogram_stuck_detector_top");
    end else begin
      $display("FAIL byte_histogram_stuck_detector_top");
    end
    $finish;
  end

endmodule

// ===== byte_histogram_stuck_detector_top.f =====
hdl/bhsd_pkg.sv
hdl/bhsd_bin_mem.sv
hdl/bhsd_update.sv
hdl/byte_histogram_stuck_detector_top.sv
tb/byte_histogram_stuck_detector_top_tb.sv
